// ===== design/pcat_pkg.sv =====
// ----------------------------------------------------------------------------
// pcat_pkg: shared types and constants for the point cloud transform
// Coordinate format, rotation matrix widths, mode and register codes, and the
// configuration bundle passed from the register bank to the datapath.
// ----------------------------------------------------------------------------
package pcat_pkg;

   // coordinate fraction bits (Q15.16 by default)
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W         = 32;
   localparam int QUAT_W          = 16;

   // rotation matrix: exact entries in Q.28, rounded to Q.ROT_FRAC
   localparam int ROT_FRAC  = 24;
   localparam int MAT_SHIFT = 28 - ROT_FRAC;
   localparam int PROD_W    = 2 * QUAT_W;
   localparam int MAT_RAW_W = PROD_W + 2;
   localparam int MAT_W     = MAT_RAW_W - MAT_SHIFT;

   // datapath widths
   localparam int DIFF_W = COORD_W + 1;
   localparam int ACC_W  = 64;
   localparam int SCL_W  = ACC_W - COORD_FRAC_BITS;
   localparam int ROT_W  = ACC_W - ROT_FRAC;
   localparam int RES_W  = ((SCL_W > ROT_W) ? SCL_W : ROT_W) + 1;

   localparam int PIPE_DEPTH = 6;

   localparam logic signed [ACC_W-1:0] ROT_HALF   = ACC_W'(64'sd1 <<< (ROT_FRAC - 1));
   localparam logic signed [ACC_W-1:0] SCALE_HALF =
      ACC_W'(64'sd1 <<< (COORD_FRAC_BITS - 1));

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

   localparam logic [31:0] SCALE_ONE    = 32'(1 << COORD_FRAC_BITS);
   localparam logic [31:0] QUAT_ID_WX   = 32'h4000_0000;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_SCALE     = 2'd1,
      MODE_ROTATE    = 2'd2,
      MODE_PASS      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE     = 3'd0,
      CSR_ORIGIN_X = 3'd1,
      CSR_ORIGIN_Y = 3'd2,
      CSR_ORIGIN_Z = 3'd3,
      CSR_SCALE    = 3'd4,
      CSR_QUAT_WX  = 3'd5,
      CSR_QUAT_YZ  = 3'd6
   } csr_index_type;

   typedef struct packed {
      mode_type                   mode;
      logic signed [COORD_W-1:0]  origin_x;
      logic signed [COORD_W-1:0]  origin_y;
      logic signed [COORD_W-1:0]  origin_z;
      logic signed [COORD_W-1:0]  scale;
      logic [31:0]                quat_wx;
      logic [31:0]                quat_yz;
   } cfg_type;

   // round half up from Q.28 to Q.ROT_FRAC
   function automatic logic signed [MAT_W-1:0] mat_round(
         input logic signed [MAT_RAW_W-1:0] v);
      logic signed [MAT_RAW_W-1:0] t;
      t = v + MAT_RAW_W'(1 << (MAT_SHIFT - 1));
      return t[MAT_RAW_W-1:MAT_SHIFT];
   endfunction

endpackage

// ===== design/point_cloud_affine_transform.sv =====
// ----------------------------------------------------------------------------
// point_cloud_affine_transform: streaming 3D point transform
// Translate, scale about an origin, or quaternion rotate about an origin,
// with saturation of the signed Q15.16 result.
// ----------------------------------------------------------------------------
// Usage: a point is taken at every clock edge where start is high (busy is
// always low, so one point per cycle is sustained). Its result comes out on
// the rsp_ ports marked by a one-cycle rsp_valid strobe; the receiver must
// take it then, as nothing holds results back. The datapath has six register
// stages: origin subtract, spare alignment stage, multiply (matrix row or
// scale factor), three-term sum, rounding plus origin add, then clamp into
// the output register. Configuration must be written over csr_ (always
// ready) only while no point is in flight; the block does not enforce this.
// The rotation matrix is rebuilt from the quaternion registers through its
// product registers and then its entry registers; a point taken right after
// a quaternion write reaches the multiplier only after that, so no extra
// wait is needed. Mode three passes points through.
// ----------------------------------------------------------------------------
module point_cloud_affine_transform import pcat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // item input
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic [31:0]               req_mass_charge,
   // result output
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [31:0]               rsp_mass_charge_out,
   output logic                      rsp_saturated,
   // configuration write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   cfg_type cfg;
   logic signed [MAT_W-1:0] mat [9];

   logic signed [COORD_W-1:0] pos [3];
   logic signed [COORD_W-1:0] org [3];

   // valid bits, one per stage
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   // mass word rides along every stage
   logic [31:0] mc_ff [PIPE_DEPTH];

   // stage 1/2: p - o, and the linear pass value (d or p)
   logic signed [DIFF_W-1:0] d1_ff [3];
   logic signed [DIFF_W-1:0] lin1_ff [3];
   logic signed [DIFF_W-1:0] d2_ff [3];
   logic signed [DIFF_W-1:0] lin2_ff [3];
   // stage 3: products
   logic signed [ACC_W-1:0]  prod3_ff [9];
   logic signed [ACC_W-1:0]  sprod3_ff [3];
   logic signed [DIFF_W-1:0] lin3_ff [3];
   // stage 4: accumulated value
   logic signed [ACC_W-1:0]  acc4_ff [3];
   logic signed [ACC_W-1:0]  acc4_in [3];
   logic signed [DIFF_W-1:0] lin4_ff [3];
   // stage 5: unclamped result
   logic signed [RES_W-1:0]  res5_ff [3];
   logic signed [RES_W-1:0]  res5_in [3];
   // stage 6: output registers
   logic signed [COORD_W-1:0] out_ff [3];
   logic signed [COORD_W-1:0] out_in [3];
   logic                      sat_ff;
   logic                      sat_in;

   logic signed [ACC_W-1:0]   rnd [3];

   pcat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcat_rot_matrix u_rot (
      .clock   (clock),
      .quat_wx (cfg.quat_wx),
      .quat_yz (cfg.quat_yz),
      .mat     (mat)
   );

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;
   assign org[0] = cfg.origin_x;
   assign org[1] = cfg.origin_y;
   assign org[2] = cfg.origin_z;

   // fully pipelined, never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mc_ff[0] <= req_mass_charge;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
         mc_ff[s] <= mc_ff[s-1];
      end
   end

   // stage 1: subtract origin
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d1_ff[i] <= DIFF_W'(pos[i]) - DIFF_W'(org[i]);
         if (cfg.mode == MODE_PASS) begin
            lin1_ff[i] <= DIFF_W'(pos[i]);
         end else begin
            lin1_ff[i] <= DIFF_W'(pos[i]) - DIFF_W'(org[i]);
         end
      end
   end

   // stage 2: alignment with the matrix build after a quaternion write
   always_ff @(posedge clock) begin
      d2_ff   <= d1_ff;
      lin2_ff <= lin1_ff;
   end

   // stage 3: matrix row products and scale products
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod3_ff[3*i+j] <= ACC_W'(mat[3*i+j]) * ACC_W'(d2_ff[j]);
         end
         sprod3_ff[i] <= ACC_W'(d2_ff[i]) * ACC_W'(cfg.scale);
      end
      lin3_ff <= lin2_ff;
   end

   // stage 4: dot product sum, or the scale product
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (cfg.mode == MODE_ROTATE) begin
            acc4_in[i] = prod3_ff[3*i] + prod3_ff[3*i+1] + prod3_ff[3*i+2];
         end else begin
            acc4_in[i] = sprod3_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc4_ff <= acc4_in;
      lin4_ff <= lin3_ff;
   end

   // stage 5: round half up and add origin back (rotate, scale), else pass the linear value
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i] = '0;
         case (cfg.mode)
            MODE_ROTATE: begin
               rnd[i]     = acc4_ff[i] + ROT_HALF;
               res5_in[i] = RES_W'(rnd[i] >>> ROT_FRAC) + RES_W'(org[i]);
            end
            MODE_SCALE: begin
               rnd[i]     = acc4_ff[i] + SCALE_HALF;
               res5_in[i] = RES_W'(rnd[i] >>> COORD_FRAC_BITS) + RES_W'(org[i]);
            end
            default: begin
               res5_in[i] = RES_W'(lin4_ff[i]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res5_ff <= res5_in;
   end

   // stage 6: clamp to 32-bit signed
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (res5_ff[i] > RES_W'(COORD_MAX)) begin
            out_in[i] = COORD_MAX;
            sat_in    = 1'b1;
         end else if (res5_ff[i] < RES_W'(COORD_MIN)) begin
            out_in[i] = COORD_MIN;
            sat_in    = 1'b1;
         end else begin
            out_in[i] = res5_ff[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid           = vld_ff[PIPE_DEPTH-1];
   assign rsp_out_x           = out_ff[0];
   assign rsp_out_y           = out_ff[1];
   assign rsp_out_z           = out_ff[2];
   assign rsp_mass_charge_out = mc_ff[PIPE_DEPTH-1];
   assign rsp_saturated       = sat_ff;

endmodule

// ===== design/pcat_csr.sv =====
// ----------------------------------------------------------------------------
// pcat_csr: configuration register bank
// Holds mode, origin, scale and quaternion; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module pcat_csr import pcat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:     cfg_in.mode     = mode_type'(csr_wdata[1:0]);
            CSR_ORIGIN_X: cfg_in.origin_x = csr_wdata;
            CSR_ORIGIN_Y: cfg_in.origin_y = csr_wdata;
            CSR_ORIGIN_Z: cfg_in.origin_z = csr_wdata;
            CSR_SCALE:    cfg_in.scale    = csr_wdata;
            CSR_QUAT_WX:  cfg_in.quat_wx  = csr_wdata;
            CSR_QUAT_YZ:  cfg_in.quat_yz  = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_TRANSLATE;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.scale    <= SCALE_ONE;
         cfg_ff.quat_wx  <= QUAT_ID_WX;
         cfg_ff.quat_yz  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/pcat_rot_matrix.sv =====
// ----------------------------------------------------------------------------
// pcat_rot_matrix: quaternion to rotation matrix
// Two register stages: quaternion products, then rounded Q.24 entries.
// ----------------------------------------------------------------------------
module pcat_rot_matrix import pcat_pkg::*; (
   input  logic                    clock,
   input  logic [31:0]             quat_wx,
   input  logic [31:0]             quat_yz,
   output logic signed [MAT_W-1:0] mat [9]
);

   logic signed [QUAT_W-1:0] qw, qx, qy, qz;

   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   logic signed [MAT_RAW_W-1:0] raw [9];
   logic signed [MAT_W-1:0]     mat_ff [9];
   logic signed [MAT_W-1:0]     mat_in [9];

   assign qw = quat_wx[31:16];
   assign qx = quat_wx[15:0];
   assign qy = quat_yz[31:16];
   assign qz = quat_yz[15:0];

   always_ff @(posedge clock) begin
      ww_ff <= PROD_W'(qw) * PROD_W'(qw);
      xx_ff <= PROD_W'(qx) * PROD_W'(qx);
      yy_ff <= PROD_W'(qy) * PROD_W'(qy);
      zz_ff <= PROD_W'(qz) * PROD_W'(qz);
      xy_ff <= PROD_W'(qx) * PROD_W'(qy);
      xz_ff <= PROD_W'(qx) * PROD_W'(qz);
      yz_ff <= PROD_W'(qy) * PROD_W'(qz);
      wx_ff <= PROD_W'(qw) * PROD_W'(qx);
      wy_ff <= PROD_W'(qw) * PROD_W'(qy);
      wz_ff <= PROD_W'(qw) * PROD_W'(qz);
   end

   always_comb begin
      raw[0] = MAT_RAW_W'(ww_ff) + MAT_RAW_W'(xx_ff) - MAT_RAW_W'(yy_ff) - MAT_RAW_W'(zz_ff);
      raw[1] = (MAT_RAW_W'(xy_ff) - MAT_RAW_W'(wz_ff)) <<< 1;
      raw[2] = (MAT_RAW_W'(xz_ff) + MAT_RAW_W'(wy_ff)) <<< 1;
      raw[3] = (MAT_RAW_W'(xy_ff) + MAT_RAW_W'(wz_ff)) <<< 1;
      raw[4] = MAT_RAW_W'(ww_ff) - MAT_RAW_W'(xx_ff) + MAT_RAW_W'(yy_ff) - MAT_RAW_W'(zz_ff);
      raw[5] = (MAT_RAW_W'(yz_ff) - MAT_RAW_W'(wx_ff)) <<< 1;
      raw[6] = (MAT_RAW_W'(xz_ff) - MAT_RAW_W'(wy_ff)) <<< 1;
      raw[7] = (MAT_RAW_W'(yz_ff) + MAT_RAW_W'(wx_ff)) <<< 1;
      raw[8] = MAT_RAW_W'(ww_ff) - MAT_RAW_W'(xx_ff) - MAT_RAW_W'(yy_ff) + MAT_RAW_W'(zz_ff);
      for (int i = 0; i < 9; i++) begin
         mat_in[i] = mat_round(raw[i]);
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign mat = mat_ff;

endmodule

// ===== design/pcat_checker.sv =====
// ----------------------------------------------------------------------------
// pcat_checker: port-level checks for the point cloud transform
// Fixed latency, pass-through of the mass word, and clamp consistency.
// ----------------------------------------------------------------------------
module pcat_checker import pcat_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [31:0]               req_mass_charge,
   input logic                      rsp_valid,
   input logic signed [COORD_W-1:0] rsp_out_x,
   input logic signed [COORD_W-1:0] rsp_out_y,
   input logic signed [COORD_W-1:0] rsp_out_z,
   input logic [31:0]               rsp_mass_charge_out,
   input logic                      rsp_saturated
);

   // every accepted item shows up as a result with rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("item result missing at fixed latency");

   // no result without an earlier accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without an accepted item");

   // mass word travels unchanged with its item
   a_mass_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mass_charge_out == $past(req_mass_charge, 6))
      else $error("mass word corrupted");

   // saturation flag implies some coordinate sits at a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == COORD_MAX || rsp_out_x == COORD_MIN ||
          rsp_out_y == COORD_MAX || rsp_out_y == COORD_MIN ||
          rsp_out_z == COORD_MAX || rsp_out_z == COORD_MIN))
      else $error("saturation flag without clamped coordinate");

endmodule

bind point_cloud_affine_transform pcat_checker u_pcat_checker (.*);
